FILE: src/csvrt_pkg.sv
`default_nettype none

package csvrt_pkg;

  // character codes the tokenizer reacts to
  localparam logic [15:0] CH_BOM   = 16'hFEFF;
  localparam logic [15:0] CH_QUOTE = 16'h0022;
  localparam logic [15:0] CH_COMMA = 16'h002C;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_LF    = 16'h000A;

  // input kind codes
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  // quoting modes
  typedef enum logic [1:0] {
    MODE_UNQ   = 2'd0,
    MODE_QUO   = 2'd1,
    MODE_QSEEN = 2'd2
  } quote_mode_t;

  // one result item
  typedef struct packed {
    logic        char_valid;
    logic [15:0] out_char;
    logic        field_end;
    logic        record_end;
    logic        is_header;
    logic        empty_error;
  } token_t;

endpackage

`default_nettype wire

FILE: src/csv_record_tokenizer.sv
`default_nettype none

// CSV tokenizer for a stream of UTF-16 code units. Each slave transfer carries one character
// (tuser low) or an end-of-input mark (tuser high); each master transfer carries one token: a
// field character with quotes unescaped, a field end on a comma, or a field end with record
// end (tlast) on LF, CR or CRLF. A leading byte-order mark, the LF of a CRLF, quote marks and
// blank lines after the header give no token. The first record is flagged as the header, and
// an end of input with no character seen gives a single token with only the empty-document
// error flag set. End of input closes any open record and returns the tokenizer to its reset
// state for the next document. One character is taken every clock cycle while tready is high;
// the whole parser state update is combinational, and each token is registered in the output
// register, or in the skid register while the master side stalls. The skid register keeps the
// slave side open for one more transfer during a stall; tready drops only when it is full.
module csv_record_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] ch
  input  wire logic        s_axis_tuser,   // [0] kind
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [15:0] out_char
  output      logic [3:0]  m_axis_tuser,   // [0] char_valid, [1] field_end,
                                           // [2] is_header, [3] empty_error
  output      logic        m_axis_tlast    // record_end
);
  import csvrt_pkg::*;

  // parser state
  quote_mode_t quote_mode, quote_mode_next;
  logic        row_open, row_open_next;
  logic        header_done, header_done_next;
  logic        cr_pending, cr_pending_next;
  logic        any_seen, any_seen_next;

  // output and skid registers
  token_t      out_tok;
  token_t      skid_tok;
  logic        skid_valid;

  token_t      tok;
  logic        has_tok;
  logic        in_take;
  logic        out_take;

  logic [15:0] ch;
  logic        is_eol;
  logic        skip_lf;
  logic        unq_path;

  assign ch       = s_axis_tdata;
  assign is_eol   = (ch == CH_CR) || (ch == CH_LF);
  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // state update and token for the character at the slave side
  always_comb begin
    quote_mode_next  = quote_mode;
    row_open_next    = row_open;
    header_done_next = header_done;
    cr_pending_next  = cr_pending;
    any_seen_next    = any_seen;
    tok              = '0;
    tok.is_header    = !header_done;
    has_tok          = 1'b0;
    skip_lf          = 1'b0;
    unq_path         = 1'b0;

    if (s_axis_tuser == KIND_EOI) begin
      if (!any_seen) begin
        has_tok         = 1'b1;
        tok.is_header   = 1'b0;
        tok.empty_error = 1'b1;
      end else if (row_open || !header_done) begin
        has_tok        = 1'b1;
        tok.field_end  = 1'b1;
        tok.record_end = 1'b1;
      end
      quote_mode_next  = MODE_UNQ;
      row_open_next    = 1'b0;
      header_done_next = 1'b0;
      cr_pending_next  = 1'b0;
      any_seen_next    = 1'b0;
    end else begin
      any_seen_next = 1'b1;
      if (any_seen || ch != CH_BOM) begin
        // swallow the lf of a crlf
        if (cr_pending) begin
          cr_pending_next = 1'b0;
          skip_lf         = (ch == CH_LF);
        end
        if (!skip_lf) begin
          case (quote_mode)
            MODE_QUO: begin
              row_open_next = 1'b1;
              if (ch == CH_QUOTE) begin
                quote_mode_next = MODE_QSEEN;
              end else begin
                has_tok        = 1'b1;
                tok.char_valid = 1'b1;
                tok.out_char   = ch;
              end
            end
            MODE_QSEEN: begin
              if (ch == CH_QUOTE) begin
                quote_mode_next = MODE_QUO;
                has_tok         = 1'b1;
                tok.char_valid  = 1'b1;
                tok.out_char    = CH_QUOTE;
              end else begin
                unq_path = 1'b1;
              end
            end
            default: begin
              unq_path = 1'b1;
            end
          endcase

          // unquoted handling
          if (unq_path) begin
            quote_mode_next = MODE_UNQ;
            if (is_eol) begin
              if (row_open || !header_done) begin
                header_done_next = 1'b1;
                row_open_next    = 1'b0;
                cr_pending_next  = (ch == CH_CR);
                has_tok          = 1'b1;
                tok.field_end    = 1'b1;
                tok.record_end   = 1'b1;
              end
            end else begin
              row_open_next = 1'b1;
              if (ch == CH_QUOTE) begin
                quote_mode_next = MODE_QUO;
              end else if (ch == CH_COMMA) begin
                has_tok       = 1'b1;
                tok.field_end = 1'b1;
              end else begin
                has_tok        = 1'b1;
                tok.char_valid = 1'b1;
                tok.out_char   = ch;
              end
            end
          end
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode  <= MODE_UNQ;
      row_open    <= 1'b0;
      header_done <= 1'b0;
      cr_pending  <= 1'b0;
      any_seen    <= 1'b0;
    end else if (in_take) begin
      quote_mode  <= quote_mode_next;
      row_open    <= row_open_next;
      header_done <= header_done_next;
      cr_pending  <= cr_pending_next;
      any_seen    <= any_seen_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_take && has_tok) begin
      if (!m_axis_tvalid || out_take) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // payload of the output and skid registers
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_tok <= skid_tok;
      end
    end else if (in_take && has_tok) begin
      if (!m_axis_tvalid || out_take) begin
        out_tok <= tok;
      end else begin
        skid_tok <= tok;
      end
    end
  end

  assign s_axis_tready = !skid_valid;
  assign m_axis_tdata  = out_tok.out_char;
  assign m_axis_tuser  = {out_tok.empty_error, out_tok.is_header,
                          out_tok.field_end, out_tok.char_valid};
  assign m_axis_tlast  = out_tok.record_end;

  // a full skid register always sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid register full while output register empty");

  // a record end always closes a field too
  a_record_closes_field: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[1])
    else $error("record end without field end");

  // the empty-document token carries no other flag
  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3]) |->
      (!m_axis_tuser[0] && !m_axis_tuser[1] && !m_axis_tuser[2] && !m_axis_tlast))
    else $error("empty-document token with other flags");

  // end of input leaves the parser in its reset state
  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    (in_take && s_axis_tuser == KIND_EOI) |=>
      (!any_seen && !row_open && !header_done && !cr_pending && quote_mode == MODE_UNQ))
    else $error("parser state not cleared after end of input");

  // a token without a character carries a zero character code
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("character code on a token without a character");

endmodule

`default_nettype wire
